// ----- rtl/slt_pkg.sv -----
// Package for the shell line tokenizer: result type, codes and byte classifiers.
package slt_pkg;

	localparam int MaxResults = 3;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_END  = 2'd1,
		KIND_OP   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		SM_IDLE  = 2'd0,
		SM_WORD  = 2'd1,
		SM_QUOTE = 2'd2
	} scan_t;

	// pending doubling operator
	typedef enum logic [2:0] {
		PO_NONE = 3'd0,
		PO_LT   = 3'd1,
		PO_GT   = 3'd2,
		PO_BAR  = 3'd3,
		PO_AMP  = 3'd4
	} pend_t;

	localparam logic [3:0] OP_CARET = 4'd8;
	localparam logic [3:0] OP_LPAR  = 4'd9;
	localparam logic [3:0] OP_RPAR  = 4'd10;

	localparam logic [1:0] QT_SINGLE = 2'd0;
	localparam logic [1:0] QT_DOUBLE = 2'd1;
	localparam logic [1:0] QT_BACK   = 2'd2;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] byte_value;
		logic [3:0] op_code;
		logic       first_byte;
		logic       quoted;
	} res_t;

	function automatic res_t mk_res(kind_t k, logic [7:0] b, logic [3:0] op, logic f,
			logic q);
		res_t r;
		r.kind       = k;
		r.byte_value = b;
		r.op_code    = op;
		r.first_byte = f;
		r.quoted     = q;
		return r;
	endfunction

	function automatic pend_t dbl_index(logic [7:0] c);
		pend_t p;
		unique case (c)
			8'h3C:   p = PO_LT;
			8'h3E:   p = PO_GT;
			8'h7C:   p = PO_BAR;
			8'h26:   p = PO_AMP;
			default: p = PO_NONE;
		endcase
		return p;
	endfunction

	function automatic logic [7:0] dbl_char(pend_t p);
		logic [7:0] c;
		unique case (p)
			PO_LT:   c = 8'h3C;
			PO_GT:   c = 8'h3E;
			PO_BAR:  c = 8'h7C;
			PO_AMP:  c = 8'h26;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// single operator code of a pending operator; double code is this plus one
	function automatic logic [3:0] pend_code(pend_t p);
		logic [3:0] base;
		base = {1'b0, p} - 4'd1;
		return {base[2:0], 1'b0};
	endfunction

	function automatic logic is_solo(logic [7:0] c);
		return c == 8'h5E || c == 8'h28 || c == 8'h29;
	endfunction

	function automatic logic [3:0] solo_code(logic [7:0] c);
		logic [3:0] op;
		unique case (c)
			8'h5E:   op = OP_CARET;
			8'h28:   op = OP_LPAR;
			default: op = OP_RPAR;
		endcase
		return op;
	endfunction

	function automatic logic is_sep(logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0A;
	endfunction

	function automatic logic is_quote(logic [7:0] c);
		return c == 8'h27 || c == 8'h22 || c == 8'h60;
	endfunction

	function automatic logic [1:0] quote_idx(logic [7:0] c);
		logic [1:0] q;
		unique case (c)
			8'h27:   q = QT_SINGLE;
			8'h22:   q = QT_DOUBLE;
			default: q = QT_BACK;
		endcase
		return q;
	endfunction

	function automatic logic [7:0] quote_char(logic [1:0] q);
		logic [7:0] c;
		unique case (q)
			QT_SINGLE: c = 8'h27;
			QT_DOUBLE: c = 8'h22;
			QT_BACK:   c = 8'h60;
			default:   c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/shell_line_tokenizer_top.sv -----
// Shell line tokenizer: byte stream in, token events out.
//
// Input channel (in_valid/in_ready, ch, line_end) takes one byte of a command
// line per transfer. Output channel (out_valid/out_ready, kind, byte_value,
// op_code, first_byte, quoted, last_result) gives token events one per transfer.
// Each input byte yields zero to three events; last_result marks the final one.
// Events of a byte are decoded in the cycle of its transfer and land in a
// three-entry result register, so the first event is valid the next cycle.
// A byte with k events holds the result register for k output transfers; the
// input is ready again in the cycle the last of them goes out, so bytes that
// yield at most one event stream at one per cycle. Bytes with no event leave
// the result register empty and the next byte is taken right away.
// Scanner state (mode, open quote, pending operator) updates on each input
// transfer. If the receiver stalls, the current event holds and the input
// stalls once the result register cannot drain in that cycle.
// Reset clears the scanner to between tokens and empties the result register.
module shell_line_tokenizer_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          ch,
	input  logic                line_end,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          kind,
	output logic [7:0]          byte_value,
	output logic [3:0]          op_code,
	output logic                first_byte,
	output logic                quoted,
	output logic                last_result
);
	import slt_pkg::*;

	// scanner state
	scan_t      scan_q;
	logic [1:0] quote_q;
	pend_t      pend_q;
	logic       has_bytes_q;

	// result register: up to three events, drained from rd_q
	res_t       res_q [MaxResults];
	logic [1:0] cnt_q;
	logic [1:0] rd_q;

	// decode results
	scan_t      scan_d;
	logic [1:0] quote_d;
	pend_t      pend_d;
	logic       has_bytes_d;
	res_t       res_d [MaxResults];
	logic [1:0] n_d;

	logic in_fire, out_fire;
	res_t cur;

	assign out_valid = cnt_q != 2'd0;
	assign in_ready  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	// single-pass decode of one byte against the current state
	always_comb begin
		logic consumed;
		logic le;
		pend_t d;
		scan_d      = scan_q;
		quote_d     = quote_q;
		pend_d      = pend_q;
		has_bytes_d = has_bytes_q;
		n_d         = 2'd0;
		consumed    = 1'b0;
		le          = line_end;
		d           = dbl_index(ch);
		for (int i = 0; i < MaxResults; i++) begin
			res_d[i] = mk_res(KIND_BYTE, 8'd0, 4'd0, 1'b0, 1'b0);
		end

		// pending operator: double it or flush it as single
		if (pend_q != PO_NONE) begin
			if (ch == dbl_char(pend_q)) begin
				res_d[n_d] = mk_res(KIND_OP, 8'd0, pend_code(pend_q) + 4'd1, 1'b0, 1'b0);
				consumed   = 1'b1;
			end else begin
				res_d[n_d] = mk_res(KIND_OP, 8'd0, pend_code(pend_q), 1'b0, 1'b0);
			end
			n_d    = n_d + 2'd1;
			pend_d = PO_NONE;
		end

		// zero byte ends the line
		if (!consumed && ch == 8'd0) begin
			if (scan_d == SM_WORD || scan_d == SM_QUOTE) begin
				res_d[n_d] = mk_res(KIND_END, 8'd0, 4'd0, 1'b0, scan_d == SM_QUOTE);
				n_d        = n_d + 2'd1;
			end
			scan_d      = SM_IDLE;
			has_bytes_d = 1'b0;
			le          = 1'b0;
			consumed    = 1'b1;
		end

		if (!consumed) begin
			unique case (scan_q)
				SM_QUOTE: begin
					if (ch == quote_char(quote_q)) begin
						res_d[n_d]  = mk_res(KIND_END, 8'd0, 4'd0, 1'b0, 1'b1);
						n_d         = n_d + 2'd1;
						scan_d      = SM_IDLE;
						has_bytes_d = 1'b0;
					end else begin
						res_d[n_d]  = mk_res(KIND_BYTE, ch, 4'd0, !has_bytes_q, 1'b1);
						n_d         = n_d + 2'd1;
						has_bytes_d = 1'b1;
					end
				end
				SM_WORD: begin
					if (is_sep(ch) || d != PO_NONE || is_solo(ch)) begin
						res_d[n_d]  = mk_res(KIND_END, 8'd0, 4'd0, 1'b0, 1'b0);
						n_d         = n_d + 2'd1;
						scan_d      = SM_IDLE;
						has_bytes_d = 1'b0;
						if (d != PO_NONE) begin
							pend_d = d;
						end else if (is_solo(ch)) begin
							res_d[n_d] = mk_res(KIND_OP, 8'd0, solo_code(ch), 1'b0, 1'b0);
							n_d        = n_d + 2'd1;
						end
					end else begin
						res_d[n_d]  = mk_res(KIND_BYTE, ch, 4'd0, 1'b0, 1'b0);
						n_d         = n_d + 2'd1;
						has_bytes_d = 1'b1;
					end
				end
				default: begin
					scan_d = SM_IDLE;
					if (is_sep(ch)) begin
						scan_d = SM_IDLE;
					end else if (d != PO_NONE) begin
						pend_d = d;
					end else if (is_solo(ch)) begin
						res_d[n_d] = mk_res(KIND_OP, 8'd0, solo_code(ch), 1'b0, 1'b0);
						n_d        = n_d + 2'd1;
					end else if (is_quote(ch)) begin
						scan_d      = SM_QUOTE;
						quote_d     = quote_idx(ch);
						has_bytes_d = 1'b0;
					end else begin
						scan_d      = SM_WORD;
						res_d[n_d]  = mk_res(KIND_BYTE, ch, 4'd0, 1'b1, 1'b0);
						n_d         = n_d + 2'd1;
						has_bytes_d = 1'b1;
					end
				end
			endcase
		end

		// line end: flush pending operator, close open token
		if (le) begin
			if (pend_d != PO_NONE) begin
				res_d[n_d] = mk_res(KIND_OP, 8'd0, pend_code(pend_d), 1'b0, 1'b0);
				n_d        = n_d + 2'd1;
			end
			pend_d = PO_NONE;
			if (scan_d == SM_WORD || scan_d == SM_QUOTE) begin
				res_d[n_d] = mk_res(KIND_END, 8'd0, 4'd0, 1'b0, scan_d == SM_QUOTE);
				n_d        = n_d + 2'd1;
			end
			scan_d      = SM_IDLE;
			has_bytes_d = 1'b0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= SM_IDLE;
			quote_q     <= QT_SINGLE;
			pend_q      <= PO_NONE;
			has_bytes_q <= 1'b0;
			cnt_q       <= 2'd0;
			rd_q        <= 2'd0;
		end else begin
			if (in_fire) begin
				scan_q      <= scan_d;
				quote_q     <= quote_d;
				pend_q      <= pend_d;
				has_bytes_q <= has_bytes_d;
				cnt_q       <= n_d;
				rd_q        <= 2'd0;
			end else if (out_fire) begin
				cnt_q <= cnt_q - 2'd1;
				rd_q  <= rd_q + 2'd1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < MaxResults; i++) begin
				res_q[i] <= res_d[i];
			end
		end
	end

	assign cur         = res_q[rd_q];
	assign kind        = cur.kind;
	assign byte_value  = cur.byte_value;
	assign op_code     = cur.op_code;
	assign first_byte  = cur.first_byte;
	assign quoted      = cur.quoted;
	assign last_result = cnt_q == 2'd1;

`ifndef SYNTHESIS
	// the drain pointer never runs past the filled entries
	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, rd_q} + {1'b0, cnt_q}) <= 3'd3)
		else $error("result pointer overrun");

	// a new byte is taken only when the last buffered event leaves
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && out_valid) |-> (cnt_q == 2'd1 && out_ready))
		else $error("result register overwritten");

	// a pending operator only exists between tokens
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q != PO_NONE) |-> (scan_q == SM_IDLE))
		else $error("pending operator inside a token");

	// a transfer of a non-final event leaves another behind
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && !last_result && !in_fire) |=> out_valid)
		else $error("events lost");
`endif

endmodule

// ----- bench/shell_line_tokenizer_top_test.sv -----
// Self-checking testbench for shell_line_tokenizer_top: directed table, random lines, scoreboard.
module shell_line_tokenizer_top_test;
	import slt_pkg::*;

	// Run limit in clock cycles. The slowest legal run has roughly 360 bytes of three events
	// each, with long receiver stalls and sender gaps.
	localparam int unsigned CycleLimit = 200000;
	localparam int RandomPerPhase = 105;
	localparam int MaxPrinted = 40;

	// bytes with a meaning of their own on the command line
	localparam logic [7:0] C_NUL   = 8'h00;
	localparam logic [7:0] C_TAB   = 8'h09;
	localparam logic [7:0] C_NL    = 8'h0A;
	localparam logic [7:0] C_SP    = 8'h20;
	localparam logic [7:0] C_DQ    = 8'h22;
	localparam logic [7:0] C_AMP   = 8'h26;
	localparam logic [7:0] C_SQ    = 8'h27;
	localparam logic [7:0] C_LPAR  = 8'h28;
	localparam logic [7:0] C_RPAR  = 8'h29;
	localparam logic [7:0] C_LT    = 8'h3C;
	localparam logic [7:0] C_GT    = 8'h3E;
	localparam logic [7:0] C_CARET = 8'h5E;
	localparam logic [7:0] C_BQ    = 8'h60;
	localparam logic [7:0] C_BAR   = 8'h7C;

	// operator codes not named in the package; each doubled form is its single code plus one
	localparam logic [3:0] OP_LT   = 4'd0;
	localparam logic [3:0] OP_LTLT = 4'd1;
	localparam logic [3:0] OP_GT   = 4'd2;
	localparam logic [3:0] OP_GTGT = 4'd3;
	localparam logic [3:0] OP_PIPE = 4'd4;
	localparam logic [3:0] OP_OR   = 4'd5;
	localparam logic [3:0] OP_AMP  = 4'd6;
	localparam logic [3:0] OP_AND  = 4'd7;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] byte_value;
		logic [3:0] op_code;
		logic       first_byte;
		logic       quoted;
		logic       last_result;
	} token_event_t;

	// one row of the directed table; fixed rows carry their events typed in
	typedef struct packed {
		logic [7:0]              c;
		logic                    le;
		logic                    fixed;
		logic [1:0]              n;
		token_event_t [2:0]      ev;
	} stim_row_t;

	localparam token_event_t NO_EV = '0;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] ch        = 8'h00;
	logic       line_end  = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] kind;
	logic [7:0] byte_value;
	logic [3:0] op_code;
	logic       first_byte;
	logic       quoted;
	logic       last_result;

	shell_line_tokenizer_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.ch          (ch),
		.line_end    (line_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.byte_value  (byte_value),
		.op_code     (op_code),
		.first_byte  (first_byte),
		.quoted      (quoted),
		.last_result (last_result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	int unsigned cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	int mismatches = 0;
	int items_sent = 0;
	int send_gap_pct = 15;
	int take_stall_pct = 80;

	// Scanner state as the predictor sees it.
	scan_t      scan_state = SM_IDLE;
	logic [1:0] open_q     = QT_SINGLE;
	pend_t      held_op    = PO_NONE;
	logic       got_content = 1'b0;

	token_event_t step_events[$];   // events of the byte being predicted
	token_event_t events_due[$];    // events predicted but not yet seen on the output

	// Row of the transfer currently offered; the monitor reads it at acceptance.
	logic               row_fixed_now = 1'b0;
	logic [1:0]         row_count = 2'd0;
	token_event_t [2:0] row_events = '0;

	logic [7:0] op_chars[7] = '{C_LT, C_GT, C_BAR, C_AMP, C_CARET, C_LPAR, C_RPAR};

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= MaxPrinted)
			$display("cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
	endtask

	//----------------------------------------------------------------------
	// Event constructors and byte classes
	//----------------------------------------------------------------------
	function automatic token_event_t content_ev(logic [7:0] b, logic f, logic q);
		token_event_t e;
		e = '0;
		e.kind = KIND_BYTE;
		e.byte_value = b;
		e.first_byte = f;
		e.quoted = q;
		return e;
	endfunction

	function automatic token_event_t end_ev(logic q);
		token_event_t e;
		e = '0;
		e.kind = KIND_END;
		e.quoted = q;
		return e;
	endfunction

	function automatic token_event_t op_ev(logic [3:0] code);
		token_event_t e;
		e = '0;
		e.kind = KIND_OP;
		e.op_code = code;
		return e;
	endfunction

	function automatic pend_t pend_of(logic [7:0] c);
		case (c)
			C_LT:    return PO_LT;
			C_GT:    return PO_GT;
			C_BAR:   return PO_BAR;
			C_AMP:   return PO_AMP;
			default: return PO_NONE;
		endcase
	endfunction

	function automatic logic [7:0] pend_char(pend_t p);
		case (p)
			PO_LT:   return C_LT;
			PO_GT:   return C_GT;
			PO_BAR:  return C_BAR;
			PO_AMP:  return C_AMP;
			default: return C_NUL;
		endcase
	endfunction

	function automatic logic [3:0] single_code(pend_t p);
		case (p)
			PO_GT:   return OP_GT;
			PO_BAR:  return OP_PIPE;
			PO_AMP:  return OP_AMP;
			default: return OP_LT;
		endcase
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return c == C_SP || c == C_TAB || c == C_NL;
	endfunction

	function automatic logic is_operator(logic [7:0] c);
		return pend_of(c) != PO_NONE || c == C_CARET || c == C_LPAR || c == C_RPAR;
	endfunction

	function automatic logic is_quote_char(logic [7:0] c);
		return c == C_SQ || c == C_DQ || c == C_BQ;
	endfunction

	function automatic logic [1:0] quote_of(logic [7:0] c);
		case (c)
			C_SQ:    return QT_SINGLE;
			C_DQ:    return QT_DOUBLE;
			default: return QT_BACK;
		endcase
	endfunction

	function automatic logic [7:0] quote_char_of(logic [1:0] q);
		case (q)
			QT_SINGLE: return C_SQ;
			QT_DOUBLE: return C_DQ;
			QT_BACK:   return C_BQ;
			default:   return C_NUL;
		endcase
	endfunction

	//----------------------------------------------------------------------
	// Predictor
	//----------------------------------------------------------------------
	// end of the open word or quoted token, if any
	task automatic close_token();
		if (scan_state == SM_WORD)
			step_events.push_back(end_ev(1'b0));
		else if (scan_state == SM_QUOTE)
			step_events.push_back(end_ev(1'b1));
		scan_state = SM_IDLE;
		got_content = 1'b0;
	endtask

	// a held operator that did not double goes out as a single one
	task automatic emit_held();
		if (held_op != PO_NONE)
			step_events.push_back(op_ev(single_code(held_op)));
		held_op = PO_NONE;
	endtask

	task automatic start_op(input logic [7:0] c);
		if (pend_of(c) != PO_NONE)
			held_op = pend_of(c);
		else if (c == C_CARET)
			step_events.push_back(op_ev(OP_CARET));
		else if (c == C_LPAR)
			step_events.push_back(op_ev(OP_LPAR));
		else
			step_events.push_back(op_ev(OP_RPAR));
	endtask

	// Events caused by one byte, left in step_events (last_result not yet marked).
	task automatic tokenize_byte(input logic [7:0] c, input logic le);
		logic done;
		logic flush_at_end;
		step_events.delete();
		done = 1'b0;
		flush_at_end = le;
		if (held_op != PO_NONE) begin
			if (c == pend_char(held_op)) begin
				step_events.push_back(op_ev(single_code(held_op) + 4'd1));
				held_op = PO_NONE;
				done = 1'b1;
			end else begin
				emit_held();
			end
		end
		// zero byte ends the line on its own; the line_end flag adds nothing
		if (!done && c == C_NUL) begin
			close_token();
			flush_at_end = 1'b0;
			done = 1'b1;
		end
		if (!done) begin
			case (scan_state)
				SM_QUOTE: begin
					if (c == quote_char_of(open_q)) begin
						close_token();
					end else begin
						step_events.push_back(content_ev(c, !got_content, 1'b1));
						got_content = 1'b1;
					end
				end
				SM_WORD: begin
					if (is_blank(c)) begin
						close_token();
					end else if (is_operator(c)) begin
						close_token();
						start_op(c);
					end else begin
						step_events.push_back(content_ev(c, 1'b0, 1'b0));
						got_content = 1'b1;
					end
				end
				default: begin
					scan_state = SM_IDLE;
					if (is_blank(c)) begin
						// separator between tokens: nothing to report
					end else if (is_operator(c)) begin
						start_op(c);
					end else if (is_quote_char(c)) begin
						scan_state = SM_QUOTE;
						open_q = quote_of(c);
						got_content = 1'b0;
					end else begin
						scan_state = SM_WORD;
						step_events.push_back(content_ev(c, 1'b1, 1'b0));
						got_content = 1'b1;
					end
				end
			endcase
		end
		// line end: single held operator out, open token closed (also unterminated quotes)
		if (flush_at_end) begin
			emit_held();
			close_token();
		end
	endtask

	//----------------------------------------------------------------------
	// Monitor: output checks and input prediction, both sampled at the rising edge
	//----------------------------------------------------------------------
	always @(posedge clk) begin
		token_event_t want;
		int i;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (events_due.size() == 0) begin
					report_mismatch("event with none due, kind", kind, -1);
				end else begin
					want = events_due.pop_front();
					if (kind !== want.kind)
						report_mismatch("kind", kind, want.kind);
					if (byte_value !== want.byte_value)
						report_mismatch("byte_value", byte_value, want.byte_value);
					if (op_code !== want.op_code)
						report_mismatch("op_code", op_code, want.op_code);
					if (first_byte !== want.first_byte)
						report_mismatch("first_byte", first_byte, want.first_byte);
					if (quoted !== want.quoted)
						report_mismatch("quoted", quoted, want.quoted);
					if (last_result !== want.last_result)
						report_mismatch("last_result", last_result, want.last_result);
				end
			end
			if (in_valid && in_ready) begin
				// the predictor always runs so its state follows the line
				tokenize_byte(ch, line_end);
				if (row_fixed_now) begin
					step_events.delete();
					for (i = 0; i < row_count; i++)
						step_events.push_back(row_events[i]);
				end
				if (step_events.size() > 0)
					step_events[step_events.size() - 1].last_result = 1'b1;
				foreach (step_events[i])
					events_due.push_back(step_events[i]);
			end
		end
	end

	// Receiver: stalls drawn fresh every cycle, driven at the falling edge.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= take_stall_pct);
	end

	//----------------------------------------------------------------------
	// Sender
	//----------------------------------------------------------------------
	function automatic stim_row_t row_free(logic [7:0] c, logic le);
		stim_row_t r;
		r = '0;
		r.c = c;
		r.le = le;
		return r;
	endfunction

	function automatic stim_row_t row_fixed(logic [7:0] c, logic le, logic [1:0] n,
			token_event_t e0, token_event_t e1, token_event_t e2);
		stim_row_t r;
		r = row_free(c, le);
		r.fixed = 1'b1;
		r.n = n;
		r.ev[0] = e0;
		r.ev[1] = e1;
		r.ev[2] = e2;
		return r;
	endfunction

	// Offer one byte at the falling edge and hold it until the transfer.
	task automatic send_row(input stim_row_t r);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		ch <= r.c;
		line_end <= r.le;
		row_fixed_now = r.fixed;
		row_count = r.n;
		row_events = r.ev;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		items_sent++;
	endtask

	function automatic logic [7:0] word_pick();
		logic [7:0] b;
		do b = 8'($urandom_range(1, 255));
		while (is_blank(b) || is_operator(b) || is_quote_char(b));
		return b;
	endfunction

	// anything but the closing quote and zero; blanks and operators included
	function automatic logic [7:0] quoted_pick(logic [7:0] q);
		logic [7:0] b;
		do b = 8'($urandom_range(1, 255));
		while (b == q);
		return b;
	endfunction

	// A line of words, quoted strings, operators and random bytes, mostly with blanks between,
	// closed either by line_end on its last byte or by a zero byte.
	task automatic send_line();
		logic [7:0] line_bytes[$];
		logic [7:0] b;
		int ntok;
		int k;
		int j;
		logic zero_end;
		ntok = $urandom_range(1, 6);
		for (k = 0; k < ntok; k++) begin
			if (k > 0 && $urandom_range(3) != 0) begin
				repeat ($urandom_range(1, 2)) begin
					case ($urandom_range(2))
						0:       line_bytes.push_back(C_SP);
						1:       line_bytes.push_back(C_TAB);
						default: line_bytes.push_back(C_NL);
					endcase
				end
			end
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					repeat ($urandom_range(1, 5)) line_bytes.push_back(word_pick());
				end
				4, 5: begin
					case ($urandom_range(2))
						0:       b = C_SQ;
						1:       b = C_DQ;
						default: b = C_BQ;
					endcase
					line_bytes.push_back(b);
					repeat ($urandom_range(0, 4)) line_bytes.push_back(quoted_pick(b));
					// the last token is sometimes left open
					if (k < ntok - 1 || $urandom_range(3) != 0)
						line_bytes.push_back(b);
				end
				6, 7, 8: begin
					b = op_chars[$urandom_range(6)];
					line_bytes.push_back(b);
					if (pend_of(b) != PO_NONE && $urandom_range(1) == 1)
						line_bytes.push_back(b);
				end
				default: line_bytes.push_back(8'($urandom_range(255)));
			endcase
		end
		zero_end = ($urandom_range(3) == 0);
		if (zero_end)
			line_bytes.push_back(C_NUL);
		for (j = 0; j < line_bytes.size(); j++) begin
			if (j == line_bytes.size() - 1)
				send_row(row_free(line_bytes[j], zero_end ? 1'($urandom_range(1)) : 1'b1));
			else
				send_row(row_free(line_bytes[j], 1'b0));
		end
	endtask

	//----------------------------------------------------------------------
	// Main sequence
	//----------------------------------------------------------------------
	initial begin
		stim_row_t dir_rows[$];
		int phase;

		// directed table: fixed rows have their events typed in, the rest go to the predictor
		dir_rows.push_back(row_fixed(8'h61, 1'b0, 2'd1, content_ev(8'h61, 1'b1, 1'b0),
			NO_EV, NO_EV));                                           // first byte after reset
		dir_rows.push_back(row_fixed(8'hFF, 1'b0, 2'd1, content_ev(8'hFF, 1'b0, 1'b0),
			NO_EV, NO_EV));                                           // top byte in a word
		dir_rows.push_back(row_fixed(C_SP, 1'b0, 2'd1, end_ev(1'b0), NO_EV, NO_EV));
		dir_rows.push_back(row_fixed(C_LT, 1'b0, 2'd0, NO_EV, NO_EV, NO_EV));
		dir_rows.push_back(row_fixed(C_LT, 1'b0, 2'd1, op_ev(OP_LTLT), NO_EV, NO_EV));
		dir_rows.push_back(row_fixed(C_GT, 1'b0, 2'd0, NO_EV, NO_EV, NO_EV));
		dir_rows.push_back(row_fixed(C_GT, 1'b0, 2'd1, op_ev(OP_GTGT), NO_EV, NO_EV));
		dir_rows.push_back(row_free(C_BAR, 1'b0));
		dir_rows.push_back(row_fixed(8'h78, 1'b0, 2'd2, op_ev(OP_PIPE),
			content_ev(8'h78, 1'b1, 1'b0), NO_EV));                   // held pipe, then a word
		dir_rows.push_back(row_free(C_BAR, 1'b0));                   // operator ends the word
		dir_rows.push_back(row_free(C_BAR, 1'b0));
		dir_rows.push_back(row_free(C_AMP, 1'b0));
		dir_rows.push_back(row_free(C_AMP, 1'b0));
		dir_rows.push_back(row_free(C_AMP, 1'b0));
		dir_rows.push_back(row_free(C_CARET, 1'b0));                 // flushes a single amp
		dir_rows.push_back(row_free(C_LPAR, 1'b0));
		dir_rows.push_back(row_free(C_RPAR, 1'b1));
		dir_rows.push_back(row_free(C_DQ, 1'b0));
		dir_rows.push_back(row_fixed(C_DQ, 1'b0, 2'd1, end_ev(1'b1), NO_EV, NO_EV)); // empty quotes
		dir_rows.push_back(row_free(C_BQ, 1'b0));
		dir_rows.push_back(row_free(C_NL, 1'b0));                    // newline inside quotes
		dir_rows.push_back(row_free(C_LT, 1'b0));                    // operator inside quotes
		dir_rows.push_back(row_free(C_SQ, 1'b0));                    // other quote is content
		dir_rows.push_back(row_fixed(C_NUL, 1'b1, 2'd1, end_ev(1'b1), NO_EV, NO_EV)); // zero byte
		dir_rows.push_back(row_free(8'h62, 1'b0));
		dir_rows.push_back(row_free(C_SQ, 1'b0));                    // quote inside a word
		dir_rows.push_back(row_free(C_AMP, 1'b1));                   // held amp at line end
		dir_rows.push_back(row_free(C_SQ, 1'b1));                    // unterminated quote
		dir_rows.push_back(row_free(C_GT, 1'b0));
		dir_rows.push_back(row_free(C_NUL, 1'b1));                   // zero flushes held op

		// reset once, released at a falling edge
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_row(dir_rows[i]);

		// three idling regimes: sender light / receiver heavy, swapped, then none
		for (phase = 0; phase < 3; phase++) begin
			send_gap_pct = (phase == 0) ? 15 : (phase == 1) ? 80 : 0;
			take_stall_pct = (phase == 0) ? 80 : (phase == 1) ? 15 : 0;
			while (items_sent < dir_rows.size() + RandomPerPhase * (phase + 1)) begin
				if ($urandom_range(4) == 0) begin
					// noise: any byte, line_end now and then
					repeat ($urandom_range(1, 8))
						send_row(row_free(8'($urandom_range(255)), $urandom_range(9) == 0));
				end else begin
					send_line();
				end
			end
		end
		in_valid <= 1'b0;

		// drain, then keep clocking to catch stray events
		while (events_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatches == 0)
			$display("shell_line_tokenizer_top regression: pass");
		else
			$display("shell_line_tokenizer_top regression: fail");
		$finish;
	end

	// Watchdog on the cycle counter.
	initial begin
		wait (cycle_count >= CycleLimit);
		$display("shell_line_tokenizer_top regression: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/slt_pkg.sv
rtl/shell_line_tokenizer_top.sv
bench/shell_line_tokenizer_top_test.sv
